### src/tadc_pkg.sv
// Shared types and constants for the thermistor divider to temperature converter.
// Holds the segment table and the widths used by every stage; depends on nothing.
`default_nettype none

package tadc_pkg;

   // Field and datapath widths
   localparam int ADC_W       = 12;
   localparam int TEMP_W      = 17;
   localparam int RES_W       = 25;   // resistance in ohms, below 2^25 for valid inputs
   localparam int PROD_W      = 26;   // adc_mv * pull-up scale before range gating
   localparam int SCALE_W     = 14;
   localparam int DEN1_W      = 12;   // supply minus voltage
   localparam int SEG_W       = 18;   // segment bounds and bases
   localparam int SLOPE_W     = 14;
   localparam int DIFF_W      = 17;   // base minus resistance inside a window
   localparam int OFFSET_W    = 8;
   localparam int QUO_EXTRA   = 4;    // integer bits of (base - r) / slope, always below 11
   localparam int DIV_STEPS   = 5;    // restoring steps per divider stage

   localparam logic [ADC_W-1:0]   SUPPLY_MV    = 12'd3296;
   localparam logic [SCALE_W-1:0] PULLUP_SCALE = 14'd10000;

   localparam int SEG_N = 17;

   typedef struct packed {
      logic [SEG_W-1:0]           hi;      // exclusive upper bound
      logic [SEG_W-1:0]           lo;      // inclusive lower bound
      logic [SEG_W-1:0]           base;
      logic [SLOPE_W-1:0]         slope;
      logic signed [OFFSET_W-1:0] offset;  // whole degrees
   } seg_type;

   // Segment result carried alongside the second division
   typedef struct packed {
      logic                       ok;
      logic signed [OFFSET_W-1:0] offset_deg;
   } seg_info_type;

   // Tested in order; first window that holds the resistance wins
   localparam seg_type SEG_TAB [SEG_N] = '{
      '{18'd29371,  18'd18680,  18'd29370,  14'd1069,  8'sd0},
      '{18'd18681,  18'd12240,  18'd18680,  14'd644,   8'sd10},
      '{18'd12241,  18'd8221,   18'd12240,  14'd402,   8'sd20},
      '{18'd8222,   18'd5648,   18'd8221,   14'd257,   8'sd30},
      '{18'd5649,   18'd3958,   18'd5648,   14'd169,   8'sd40},
      '{18'd3959,   18'd2823,   18'd3959,   14'd114,   8'sd50},
      '{18'd2824,   18'd2047,   18'd2824,   14'd78,    8'sd60},
      '{18'd2048,   18'd1506,   18'd2048,   14'd54,    8'sd70},
      '{18'd1507,   18'd1124,   18'd1507,   14'd38,    8'sd80},
      '{18'd1125,   18'd850,    18'd1125,   14'd27,    8'sd90},
      '{18'd851,    18'd651,    18'd851,    14'd20,    8'sd100},
      '{18'd652,    18'd504,    18'd652,    14'd15,    8'sd110},
      '{18'd505,    18'd395,    18'd505,    14'd11,    8'sd120},
      '{18'd47731,  18'd29370,  18'd47730,  14'd1836,  -8'sd10},
      '{18'd80361,  18'd47730,  18'd80360,  14'd3263,  -8'sd20},
      '{18'd140001, 18'd80360,  18'd140000, 14'd5964,  -8'sd30},
      '{18'd249600, 18'd140000, 18'd249600, 14'd10960, -8'sd40}
   };

endpackage

`default_nettype wire

### src/tadc_if.sv
// Valid/ready channel interfaces for the converter's sample and result streams.
// Depends on tadc_pkg for the field widths.
`default_nettype none

interface tadc_req_if;
   logic                       valid;
   logic                       ready;
   logic [tadc_pkg::ADC_W-1:0] adc_mv;

   modport source (output valid, output adc_mv, input ready);
   modport sink   (input valid, input adc_mv, output ready);
endinterface

interface tadc_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [tadc_pkg::TEMP_W-1:0] temp_q8;
   logic                               in_range;

   modport source (output valid, output temp_q8, output in_range, input ready);
   modport sink   (input valid, input temp_q8, input in_range, output ready);
endinterface

`default_nettype wire

### src/tadc_div_pipe.sv
// Pipelined restoring divider, a few quotient bits per register stage.
// Carries a sideband word with each transaction; standalone, no package needed.
`default_nettype none

module tadc_div_pipe #(
   parameter int NUM_W  = 25,
   parameter int DEN_W  = 12,
   parameter int QUO_W  = 25,
   parameter int SIDE_W = 1,
   parameter int STEPS  = 5
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire logic [NUM_W-1:0]  in_num,
   input  wire logic [DEN_W-1:0]  in_den,
   input  wire logic [SIDE_W-1:0] in_side,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output logic [QUO_W-1:0]       out_quo,
   output logic [SIDE_W-1:0]      out_side
);

   localparam int NSTAGE = (QUO_W + STEPS - 1) / STEPS;

   // Stage outputs, gathered for the next stage
   logic              valid_q     [NSTAGE];
   logic [DEN_W-1:0]  rem_q       [NSTAGE];
   logic [QUO_W-1:0]  work_q      [NSTAGE];
   logic [DEN_W-1:0]  den_q       [NSTAGE];
   logic [SIDE_W-1:0] side_q      [NSTAGE];
   logic              stage_ready [NSTAGE];

   for (genvar s = 0; s < NSTAGE; s++) begin : g_stage
      logic              valid_ff;
      logic [DEN_W-1:0]  rem_ff;
      logic [DEN_W-1:0]  rem_in;
      logic [QUO_W-1:0]  work_ff;
      logic [QUO_W-1:0]  work_in;
      logic [DEN_W-1:0]  den_ff;
      logic [SIDE_W-1:0] side_ff;
      logic              src_valid;
      logic [DEN_W-1:0]  src_rem;
      logic [QUO_W-1:0]  src_work;
      logic [DEN_W-1:0]  src_den;
      logic [SIDE_W-1:0] src_side;
      logic              nxt_ready;

      // Seed the partial remainder with the numerator bits above the quotient, or take the previous stage
      if (s == 0) begin : g_first
         assign src_valid = in_valid;
         assign src_rem   = DEN_W'(in_num >> QUO_W);
         assign src_work  = in_num[QUO_W-1:0];
         assign src_den   = in_den;
         assign src_side  = in_side;
      end else begin : g_next
         assign src_valid = valid_q[s-1];
         assign src_rem   = rem_q[s-1];
         assign src_work  = work_q[s-1];
         assign src_den   = den_q[s-1];
         assign src_side  = side_q[s-1];
      end

      if (s == NSTAGE - 1) begin : g_tail
         assign nxt_ready = out_ready;
      end else begin : g_mid
         assign nxt_ready = stage_ready[s+1];
      end

      assign stage_ready[s] = !valid_ff || nxt_ready;

      // Shift one numerator bit into the remainder per step, quotient bit out
      always_comb begin
         logic [DEN_W:0] trial;
         logic           qbit;
         trial   = '0;
         qbit    = 1'b0;
         rem_in  = src_rem;
         work_in = src_work;
         for (int j = 0; j < STEPS; j++) begin
            if (s * STEPS + j < QUO_W) begin
               trial = {rem_in, work_in[QUO_W-1]};
               if (trial >= {1'b0, src_den}) begin
                  trial = trial - {1'b0, src_den};
                  qbit  = 1'b1;
               end else begin
                  qbit  = 1'b0;
               end
               rem_in  = trial[DEN_W-1:0];
               work_in = {work_in[QUO_W-2:0], qbit};
            end
         end
      end

      // Advance when the slot is empty or its content moves on
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (stage_ready[s]) begin
            valid_ff <= src_valid;
         end
         if (stage_ready[s] && src_valid) begin
            rem_ff  <= rem_in;
            work_ff <= work_in;
            den_ff  <= src_den;
            side_ff <= src_side;
         end
      end

      assign valid_q[s] = valid_ff;
      assign rem_q[s]   = rem_ff;
      assign work_q[s]  = work_ff;
      assign den_q[s]   = den_ff;
      assign side_q[s]  = side_ff;
   end

   assign in_ready  = stage_ready[0];
   assign out_valid = valid_q[NSTAGE-1];
   assign out_quo   = work_q[NSTAGE-1];
   assign out_side  = side_q[NSTAGE-1];

endmodule

`default_nettype wire

### src/tadc_seg_sel.sv
// Segment lookup stage: finds the first window holding the resistance and
// prepares numerator, slope and offset for the second division. Uses tadc_pkg.
`default_nettype none

module tadc_seg_sel #(
   parameter int FRAC_BITS = 8
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         in_valid,
   output logic                              in_ready,
   input  wire logic [tadc_pkg::RES_W-1:0]   in_res,
   input  wire logic                         in_ok,
   output logic                              out_valid,
   input  wire logic                         out_ready,
   output logic [tadc_pkg::DIFF_W+FRAC_BITS-1:0] out_num,
   output logic [tadc_pkg::SLOPE_W-1:0]      out_den,
   output tadc_pkg::seg_info_type            out_info
);

   import tadc_pkg::*;

   localparam int NUM_W = DIFF_W + FRAC_BITS;

   logic                valid_ff;
   logic [NUM_W-1:0]    num_ff;
   logic [NUM_W-1:0]    num_in;
   logic [SLOPE_W-1:0]  den_ff;
   logic [SLOPE_W-1:0]  den_in;
   seg_info_type        info_ff;
   seg_info_type        info_in;

   // Compare all windows; scanning from the last entry lets the first hit win
   always_comb begin
      logic                       hit;
      logic [SEG_W-1:0]           sel_base;
      logic [SLOPE_W-1:0]         sel_slope;
      logic signed [OFFSET_W-1:0] sel_offset;
      logic [DIFF_W-1:0]          diff;
      hit        = 1'b0;
      sel_base   = '0;
      sel_slope  = SLOPE_W'(1);
      sel_offset = '0;
      for (int i = SEG_N - 1; i >= 0; i--) begin
         if (in_res < RES_W'(SEG_TAB[i].hi) && in_res >= RES_W'(SEG_TAB[i].lo)) begin
            hit        = 1'b1;
            sel_base   = SEG_TAB[i].base;
            sel_slope  = SEG_TAB[i].slope;
            sel_offset = SEG_TAB[i].offset;
         end
      end
      diff = hit ? DIFF_W'(sel_base - in_res[SEG_W-1:0]) : '0;
      num_in             = NUM_W'(diff) << FRAC_BITS;
      den_in             = sel_slope;
      info_in.ok         = in_ok && hit;
      info_in.offset_deg = sel_offset;
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         num_ff  <= num_in;
         den_ff  <= den_in;
         info_ff <= info_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_num   = num_ff;
   assign out_den   = den_ff;
   assign out_info  = info_ff;

endmodule

`default_nettype wire

### src/thermistor_adc_to_temperature_top.sv
// Pipeline: ceil(25/5) + ceil((FRAC_BITS+4)/5) + 3 register stages, 11 at FRAC_BITS = 8:
//   scaling, resistance divider, segment lookup, slope divider and output register, up to five
//   quotient bits per divider stage.
// Throughput: one transaction per cycle; a stalled output only holds the stages behind it.
// Reset: synchronous, active high; clears every valid bit, no table or memory to fill.
// Depends on tadc_pkg, tadc_if, tadc_div_pipe and tadc_seg_sel.
`default_nettype none

module thermistor_adc_to_temperature_top #(
   parameter int FRAC_BITS = 8
) (
   input  wire logic  clock,
   input  wire logic  reset,
   tadc_req_if.sink   req_ch,
   tadc_rsp_if.source rsp_ch
);

   import tadc_pkg::*;

   localparam int NUM2_W = DIFF_W + FRAC_BITS;
   localparam int QUO2_W = FRAC_BITS + QUO_EXTRA;
   localparam int SUM_W  = (FRAC_BITS + OFFSET_W + 1 > TEMP_W) ?
                           FRAC_BITS + OFFSET_W + 1 : TEMP_W;

   // Scaling stage
   logic              s0_valid_ff;
   logic [RES_W-1:0]  s0_num_ff;
   logic [RES_W-1:0]  s0_num_in;
   logic [DEN1_W-1:0] s0_den_ff;
   logic [DEN1_W-1:0] s0_den_in;
   logic              s0_ok_ff;
   logic              s0_ok_in;
   logic              s0_ready;
   logic [PROD_W-1:0] s0_prod;

   // Resistance divider to segment lookup
   logic              div1_in_ready;
   logic              div1_out_valid;
   logic [RES_W-1:0]  div1_quo;
   logic              div1_ok;

   // Segment lookup to slope divider
   logic              seg_ready;
   logic              seg_valid;
   logic [NUM2_W-1:0] seg_num;
   logic [SLOPE_W-1:0] seg_den;
   seg_info_type      seg_info;

   // Slope divider to output stage
   logic              div2_in_ready;
   logic              div2_out_valid;
   logic [QUO2_W-1:0] div2_quo;
   seg_info_type      div2_info;

   // Output stage
   logic                     out_valid_ff;
   logic                     out_ready;
   logic signed [TEMP_W-1:0] temp_ff;
   logic signed [TEMP_W-1:0] temp_in;
   logic                     in_range_ff;
   logic signed [SUM_W-1:0]  off_ext;
   logic signed [SUM_W-1:0]  sum;

   // Scale the voltage and form supply minus voltage; gate off-supply inputs
   assign s0_ok_in  = req_ch.adc_mv < SUPPLY_MV;
   assign s0_prod   = PROD_W'(req_ch.adc_mv) * PROD_W'(PULLUP_SCALE);
   assign s0_num_in = s0_ok_in ? s0_prod[RES_W-1:0] : '0;
   assign s0_den_in = s0_ok_in ? DEN1_W'(SUPPLY_MV - req_ch.adc_mv) : DEN1_W'(1);
   assign s0_ready  = !s0_valid_ff || div1_in_ready;
   assign req_ch.ready = s0_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (s0_ready) begin
         s0_valid_ff <= req_ch.valid;
      end
      if (s0_ready && req_ch.valid) begin
         s0_num_ff <= s0_num_in;
         s0_den_ff <= s0_den_in;
         s0_ok_ff  <= s0_ok_in;
      end
   end

   tadc_div_pipe #(
      .NUM_W  (RES_W),
      .DEN_W  (DEN1_W),
      .QUO_W  (RES_W),
      .SIDE_W (1),
      .STEPS  (DIV_STEPS)
   ) u_div_res (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s0_valid_ff),
      .in_ready  (div1_in_ready),
      .in_num    (s0_num_ff),
      .in_den    (s0_den_ff),
      .in_side   (s0_ok_ff),
      .out_valid (div1_out_valid),
      .out_ready (seg_ready),
      .out_quo   (div1_quo),
      .out_side  (div1_ok)
   );

   tadc_seg_sel #(
      .FRAC_BITS (FRAC_BITS)
   ) u_seg_sel (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div1_out_valid),
      .in_ready  (seg_ready),
      .in_res    (div1_quo),
      .in_ok     (div1_ok),
      .out_valid (seg_valid),
      .out_ready (div2_in_ready),
      .out_num   (seg_num),
      .out_den   (seg_den),
      .out_info  (seg_info)
   );

   tadc_div_pipe #(
      .NUM_W  (NUM2_W),
      .DEN_W  (SLOPE_W),
      .QUO_W  (QUO2_W),
      .SIDE_W ($bits(seg_info_type)),
      .STEPS  (DIV_STEPS)
   ) u_div_slope (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (seg_valid),
      .in_ready  (div2_in_ready),
      .in_num    (seg_num),
      .in_den    (seg_den),
      .in_side   (seg_info),
      .out_valid (div2_out_valid),
      .out_ready (out_ready),
      .out_quo   (div2_quo),
      .out_side  (div2_info)
   );

   // Add the segment offset in fixed point, keep the low bits; zero when out of range
   assign off_ext = SUM_W'(div2_info.offset_deg);
   assign sum     = (off_ext <<< FRAC_BITS) + signed'(SUM_W'(div2_quo));
   assign temp_in = div2_info.ok ? sum[TEMP_W-1:0] : '0;
   assign out_ready = !out_valid_ff || rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= div2_out_valid;
      end
      if (out_ready && div2_out_valid) begin
         temp_ff     <= temp_in;
         in_range_ff <= div2_info.ok;
      end
   end

   assign rsp_ch.valid    = out_valid_ff;
   assign rsp_ch.temp_q8  = temp_ff;
   assign rsp_ch.in_range = in_range_ff;

endmodule

`default_nettype wire

### src/tadc_checker.sv
// Port-level checks for the converter top level, attached by bind.
// Depends on tadc_pkg for the result width and on the top level's channel ports.
`default_nettype none

module tadc_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_ready,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [tadc_pkg::TEMP_W-1:0] rsp_temp_q8,
   input wire logic                        rsp_in_range
);

   // Hold a stalled result transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_temp_q8) && $stable(rsp_in_range))
      else $error("stalled result transaction changed");

   // Drive zero temperature for out-of-range samples
   a_zero_out_of_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_in_range |-> rsp_temp_q8 == '0)
      else $error("out-of-range result carries a nonzero temperature");

   // Drop every result in flight on reset
   a_reset_flush: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Accept a sample whenever the output register can move
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("input stalled although the output side can advance");

   // Flag an unknown valid on either channel once out of reset
   a_valid_known: assert property (@(posedge clock) disable iff (reset)
      !$isunknown({req_valid, rsp_valid}))
      else $error("unknown valid on a channel");

endmodule

bind thermistor_adc_to_temperature_top tadc_checker u_tadc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_temp_q8  (rsp_ch.temp_q8),
   .rsp_in_range (rsp_ch.in_range)
);

`default_nettype wire

### verif/tb.sv
// Self-checking testbench for thermistor_adc_to_temperature_top.
// Depends on tadc_pkg, tadc_if and the RTL top; checks every result against an
// in-bench predictor of the divider resistance and segment interpolation.
`timescale 1ns / 100ps

module tb;
   import tadc_pkg::*;

   localparam int Q_FRAC      = 8;
   localparam int SUPPLY      = 3296;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_N    = 1700;
   localparam int NSEG        = 17;

   // NTC curve: windows are [lo, hi), first hit in this order wins
   localparam int SEG_HI [NSEG] = '{29371, 18681, 12241, 8222, 5649, 3959, 2824, 2048, 1507,
                                    1125, 851, 652, 505, 47731, 80361, 140001, 249600};
   localparam int SEG_LO [NSEG] = '{18680, 12240, 8221, 5648, 3958, 2823, 2047, 1506, 1124,
                                    850, 651, 504, 395, 29370, 47730, 80360, 140000};
   localparam int SEG_BASE [NSEG] = '{29370, 18680, 12240, 8221, 5648, 3959, 2824, 2048, 1507,
                                      1125, 851, 652, 505, 47730, 80360, 140000, 249600};
   localparam int SEG_SLOPE [NSEG] = '{1069, 644, 402, 257, 169, 114, 78, 54, 38, 27, 20, 15,
                                       11, 1836, 3263, 5964, 10960};
   localparam int SEG_OFFSET [NSEG] = '{0, 10, 20, 30, 40, 50, 60, 70, 80, 90, 100, 110, 120,
                                        -10, -20, -30, -40};

   typedef struct packed {
      logic [TEMP_W-1:0] temp_q8;
      logic              in_range;
   } temp_result_type;

   logic clock;
   logic reset;

   tadc_req_if req_bus ();
   tadc_rsp_if rsp_bus ();

   thermistor_adc_to_temperature_top #(.FRAC_BITS(Q_FRAC)) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   logic [ADC_W-1:0] sample_queue [$];
   temp_result_type  pending_temps [$];
   temp_result_type  want;
   int               edge_mv [NSEG + 1];
   int               send_idle_pct;
   int               recv_idle_pct;
   int               queued_total;
   int               accepted_total;
   int               fail_count;
   int               cycle_count;

   // Pull-up divider: ohms = mv * 10000 / (supply - mv), floored
   function automatic longint divider_ohms(input int mv);
      return (longint'(mv) * 10000) / (SUPPLY - mv);
   endfunction

   // Map a divider voltage to the expected temperature and range flag
   function automatic temp_result_type predict_temperature(input logic [ADC_W-1:0] mv);
      temp_result_type res;
      longint          ohms;
      longint          frac;
      res.temp_q8  = '0;
      res.in_range = 1'b0;
      if (int'(mv) < SUPPLY) begin
         ohms = divider_ohms(int'(mv));
         for (int i = 0; i < NSEG; i++) begin
            if (!res.in_range && ohms < SEG_HI[i] && ohms >= SEG_LO[i]) begin
               frac = ((longint'(SEG_BASE[i]) - ohms) <<< Q_FRAC) / SEG_SLOPE[i];
               res.temp_q8  = TEMP_W'(longint'(SEG_OFFSET[i]) * (longint'(1) <<< Q_FRAC) + frac);
               res.in_range = 1'b1;
            end
         end
      end
      return res;
   endfunction

   // Lowest voltage whose resistance reaches the given bound
   function automatic int first_mv_at(input longint ohms_min);
      for (int mv = 0; mv < SUPPLY; mv++)
         if (divider_ohms(mv) >= ohms_min) return mv;
      return SUPPLY - 1;
   endfunction

   task automatic add_sample(input int mv);
      sample_queue.push_back(ADC_W'(mv));
      queued_total++;
   endtask

   // Mostly in-supply voltages, some at or above supply, some anywhere, some hugging segment edges
   task automatic add_random_samples(input int count);
      int pick;
      int mv;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 65) begin
            mv = $urandom_range(SUPPLY - 1);
         end else if (pick < 75) begin
            mv = $urandom_range(4095, SUPPLY);
         end else if (pick < 80) begin
            mv = $urandom_range(4095);
         end else begin
            mv = edge_mv[$urandom_range(NSEG)] + $urandom_range(4) - 2;
            if (mv < 0) mv = 0;
         end
         add_sample(mv);
      end
   endtask

   always #5 clock = ~clock;

   // Driver: predict on acceptance, then present the next sample or idle
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            pending_temps.push_back(predict_temperature(req_bus.adc_mv));
            accepted_total++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_bus.valid  <= 1'b1;
               req_bus.adc_mv <= sample_queue.pop_front();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each accepted result with the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_temps.size() == 0) begin
               $error("unexpected result: temp_q8 %0d in_range %0b",
                      $signed(rsp_bus.temp_q8), rsp_bus.in_range);
               fail_count++;
            end else begin
               want = pending_temps.pop_front();
               if (rsp_bus.temp_q8 !== want.temp_q8) begin
                  $error("temp_q8 mismatch: expected %0d, actual %0d",
                         $signed(want.temp_q8), $signed(rsp_bus.temp_q8));
                  fail_count++;
               end
               if (rsp_bus.in_range !== want.in_range) begin
                  $error("in_range mismatch: expected %0b, actual %0b",
                         want.in_range, rsp_bus.in_range);
                  fail_count++;
               end
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("thermistor_adc_to_temperature_top regression: fail");
         $finish;
      end
   end

   initial begin
      int drain;
      clock          = 1'b0;
      reset          = 1'b1;
      send_idle_pct  = 11;
      recv_idle_pct  = 64;
      queued_total   = 0;
      accepted_total = 0;
      fail_count     = 0;
      cycle_count    = 0;

      // Voltages at each segment's lower edge, plus the top of the last window
      for (int i = 0; i < NSEG; i++) edge_mv[i] = first_mv_at(SEG_LO[i]);
      edge_mv[NSEG] = first_mv_at(SEG_HI[NSEG - 1]);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: field extremes, bit patterns, supply edge, segment edges
      add_sample(0);
      add_sample(4095);
      add_sample(SUPPLY - 1);
      add_sample(SUPPLY);
      add_sample(12'h800);
      add_sample(12'h7FF);
      add_sample(12'hAAA);
      add_sample(12'h555);
      for (int i = 0; i <= NSEG; i++) add_sample(edge_mv[i]);

      // Phase one: sender idles lightly, receiver stalls heavily
      add_random_samples(RANDOM_N / 3);
      while (accepted_total != queued_total) @(posedge clock);

      // Phase two: the other way round
      send_idle_pct = 64;
      recv_idle_pct = 11;
      add_random_samples(RANDOM_N / 3);
      while (accepted_total != queued_total) @(posedge clock);

      // Phase three: full rate on both sides
      send_idle_pct = 0;
      recv_idle_pct = 0;
      add_random_samples(RANDOM_N - 2 * (RANDOM_N / 3));
      while (accepted_total != queued_total) @(posedge clock);

      // Drain outstanding results, then allow for pipeline latency
      drain = 0;
      while (pending_temps.size() != 0 && drain < 2000) begin
         @(posedge clock);
         drain++;
      end
      repeat (20) @(posedge clock);
      if (pending_temps.size() != 0) begin
         $error("%0d results never arrived", pending_temps.size());
         fail_count++;
      end

      if (fail_count == 0) begin
         $display("thermistor_adc_to_temperature_top regression: pass");
      end else begin
         $display("thermistor_adc_to_temperature_top regression: fail");
      end
      $finish;
   end

endmodule
